// ----- rtl/ait_pkg.sv -----
package ait_pkg;

  localparam logic [7:0] AIT_TABLE_ID = 8'h74;
  localparam int         ResDepth     = 4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CLEN,
    PH_CTAG,
    PH_CDLEN,
    PH_CBODY,
    PH_ALEN,
    PH_AORG,
    PH_AREST,
    PH_DTAG,
    PH_DDLEN,
    PH_DBODY,
    PH_CRC,
    PH_DONE
  } ait_phase_t;

  typedef enum logic [2:0] {
    EV_COMMON_DESC,
    EV_APP_HEADER,
    EV_APP_DESC,
    EV_CRC,
    EV_SECTION_END,
    EV_WRONG_TABLE
  } ait_event_t;

  typedef struct packed {
    ait_event_t  event_kind;
    logic [31:0] org_id;
    logic [15:0] app_id;
    logic [7:0]  control_code;
    logic [7:0]  desc_tag;
    logic [8:0]  desc_size;
    logic        tag_known;
    logic [31:0] crc_value;
    logic        last_of_run;
  } ait_result_t;

  // up to two results per accepted byte, slot 0 first
  typedef struct packed {
    logic        v0;
    logic        v1;
    ait_result_t r0;
    ait_result_t r1;
  } ait_emit_t;

  function automatic logic [13:0] sat14(input logic [13:0] a, input logic [8:0] b);
    logic [14:0] s;
    s = {1'b0, a} + {6'b0, b};
    return (s > 15'd16383) ? 14'h3FFF : s[13:0];
  endfunction

  // fields not meaningful for a kind read as zero
  function automatic ait_result_t make_result(
    input ait_event_t  kind,
    input logic [31:0] org,
    input logic [15:0] app,
    input logic [7:0]  ctrl,
    input logic [7:0]  tag,
    input logic [8:0]  size,
    input logic [31:0] crc
  );
    ait_result_t r;
    logic        is_app;
    logic        is_desc;
    is_app         = (kind == EV_APP_HEADER) || (kind == EV_APP_DESC);
    is_desc        = (kind == EV_COMMON_DESC) || (kind == EV_APP_DESC);
    r.event_kind   = kind;
    r.org_id       = is_app ? org : 32'd0;
    r.app_id       = is_app ? app : 16'd0;
    r.control_code = (kind == EV_APP_HEADER) ? ctrl : 8'd0;
    r.desc_tag     = is_desc ? tag : 8'd0;
    r.desc_size    = is_desc ? size : 9'd0;
    r.tag_known    = is_desc && ((tag <= 8'h04) || (tag == 8'h06) || (tag == 8'h07));
    r.crc_value    = (kind == EV_CRC) ? crc : 32'd0;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/ait_if.sv -----
interface ait_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic [7:0] table_ident;

  modport source (output valid, data_byte, first_byte, table_ident, input ready);
  modport sink   (input valid, data_byte, first_byte, table_ident, output ready);
endinterface

interface ait_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] org_id;
  logic [15:0] app_id;
  logic [7:0]  control_code;
  logic [7:0]  desc_tag;
  logic [8:0]  desc_size;
  logic        tag_known;
  logic [31:0] crc_value;
  logic        last_of_run;

  modport source (output valid, event_kind, org_id, app_id, control_code, desc_tag,
                  desc_size, tag_known, crc_value, last_of_run, input ready);
  modport sink   (input valid, event_kind, org_id, app_id, control_code, desc_tag,
                  desc_size, tag_known, crc_value, last_of_run, output ready);
endinterface

// ----- rtl/ait_parse.sv -----
module ait_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  logic [7:0]          table_ident,
  input  logic                crc_present,
  output ait_pkg::ait_emit_t  emit
);

  ait_pkg::ait_phase_t phase, phase_next, cur_phase;
  logic [2:0]  fbc, fbc_next, cur_fbc;
  logic [31:0] acc, acc_next, cur_acc;
  logic [11:0] clen, clen_next, cur_clen;
  logic [13:0] ccnt, ccnt_next, cur_ccnt;
  logic [11:0] alen, alen_next, cur_alen;
  logic [13:0] acnt, acnt_next, cur_acnt;
  logic [11:0] adlen, adlen_next, cur_adlen;
  logic [13:0] adcnt, adcnt_next, cur_adcnt;
  logic [8:0]  dleft, dleft_next, cur_dleft;
  logic [31:0] org, org_next, cur_org;
  logic [15:0] app, app_next, cur_app;

  ait_pkg::ait_emit_t em;
  logic        desc_end;
  logic        loop_chk;
  logic [13:0] dcnt_chk;
  logic [13:0] lcnt_chk;
  logic [8:0]  size;

  always_comb begin
    // a first byte restarts from a cleared parse context
    cur_phase = first_byte ? ait_pkg::PH_CLEN : phase;
    cur_fbc   = first_byte ? 3'd0  : fbc;
    cur_acc   = first_byte ? 32'd0 : acc;
    cur_clen  = first_byte ? 12'd0 : clen;
    cur_ccnt  = first_byte ? 14'd0 : ccnt;
    cur_alen  = first_byte ? 12'd0 : alen;
    cur_acnt  = first_byte ? 14'd0 : acnt;
    cur_adlen = first_byte ? 12'd0 : adlen;
    cur_adcnt = first_byte ? 14'd0 : adcnt;
    cur_dleft = first_byte ? 9'd0  : dleft;
    cur_org   = first_byte ? 32'd0 : org;
    cur_app   = first_byte ? 16'd0 : app;

    phase_next = cur_phase;
    fbc_next   = cur_fbc;
    acc_next   = cur_acc;
    clen_next  = cur_clen;
    ccnt_next  = cur_ccnt;
    alen_next  = cur_alen;
    acnt_next  = cur_acnt;
    adlen_next = cur_adlen;
    adcnt_next = cur_adcnt;
    dleft_next = cur_dleft;
    org_next   = cur_org;
    app_next   = cur_app;

    em       = '0;
    desc_end = 1'b0;
    loop_chk = 1'b0;
    dcnt_chk = 14'd0;
    lcnt_chk = 14'd0;
    size     = {1'b0, data_byte} + 9'd2;

    if (first_byte && (table_ident != ait_pkg::AIT_TABLE_ID)) begin
      em.v0      = 1'b1;
      em.r0      = ait_pkg::make_result(ait_pkg::EV_WRONG_TABLE, 32'd0, 16'd0, 8'd0,
                                        8'd0, 9'd0, 32'd0);
      phase_next = ait_pkg::PH_DONE;
    end else begin
      unique case (cur_phase)
        ait_pkg::PH_CLEN: begin
          if (cur_fbc == 3'd0) begin
            acc_next = {28'd0, data_byte[3:0]};
            fbc_next = 3'd1;
          end else begin
            clen_next  = {cur_acc[3:0], data_byte};
            ccnt_next  = 14'd0;
            fbc_next   = 3'd0;
            phase_next = (clen_next == 12'd0) ? ait_pkg::PH_ALEN : ait_pkg::PH_CTAG;
          end
        end
        ait_pkg::PH_CTAG: begin
          acc_next   = {24'd0, data_byte};
          phase_next = ait_pkg::PH_CDLEN;
        end
        ait_pkg::PH_CDLEN: begin
          ccnt_next  = ait_pkg::sat14(cur_ccnt, size);
          em.v0      = 1'b1;
          em.r0      = ait_pkg::make_result(ait_pkg::EV_COMMON_DESC, cur_org, cur_app,
                                            8'd0, cur_acc[7:0], size, 32'd0);
          dleft_next = {1'b0, data_byte};
          if (data_byte == 8'd0) begin
            fbc_next   = 3'd0;
            phase_next = (ccnt_next >= {2'd0, cur_clen}) ? ait_pkg::PH_ALEN
                                                         : ait_pkg::PH_CTAG;
          end else begin
            phase_next = ait_pkg::PH_CBODY;
          end
        end
        ait_pkg::PH_CBODY: begin
          dleft_next = cur_dleft - 9'd1;
          if (dleft_next == 9'd0) begin
            fbc_next   = 3'd0;
            phase_next = (cur_ccnt >= {2'd0, cur_clen}) ? ait_pkg::PH_ALEN
                                                        : ait_pkg::PH_CTAG;
          end
        end
        ait_pkg::PH_ALEN: begin
          if (cur_fbc == 3'd0) begin
            acc_next = {28'd0, data_byte[3:0]};
            fbc_next = 3'd1;
          end else begin
            alen_next = {cur_acc[3:0], data_byte};
            acnt_next = 14'd0;
            loop_chk  = 1'b1;
            lcnt_chk  = 14'd0;
          end
        end
        ait_pkg::PH_AORG: begin
          org_next = {cur_org[23:0], data_byte};
          fbc_next = cur_fbc + 3'd1;
          if (fbc_next >= 3'd4) begin
            fbc_next   = 3'd0;
            phase_next = ait_pkg::PH_AREST;
          end
        end
        ait_pkg::PH_AREST: begin
          if (cur_fbc < 3'd2) begin
            app_next = {cur_app[7:0], data_byte};
            fbc_next = cur_fbc + 3'd1;
          end else if (cur_fbc == 3'd2) begin
            acc_next = {24'd0, data_byte};
            fbc_next = cur_fbc + 3'd1;
          end else if (cur_fbc == 3'd3) begin
            adlen_next = {data_byte[3:0], 8'd0};
            fbc_next   = cur_fbc + 3'd1;
          end else begin
            // last header byte: report the application, then check its loop
            adlen_next = cur_adlen | {4'd0, data_byte};
            adcnt_next = 14'd0;
            acnt_next  = ait_pkg::sat14(cur_acnt, 9'd9);
            em.v0      = 1'b1;
            em.r0      = ait_pkg::make_result(ait_pkg::EV_APP_HEADER, cur_org, cur_app,
                                              cur_acc[7:0], 8'd0, 9'd0, 32'd0);
            fbc_next   = 3'd0;
            desc_end   = 1'b1;
            dcnt_chk   = 14'd0;
            lcnt_chk   = acnt_next;
          end
        end
        ait_pkg::PH_DTAG: begin
          acc_next   = {24'd0, data_byte};
          phase_next = ait_pkg::PH_DDLEN;
        end
        ait_pkg::PH_DDLEN: begin
          adcnt_next = ait_pkg::sat14(cur_adcnt, size);
          acnt_next  = ait_pkg::sat14(cur_acnt, size);
          em.v0      = 1'b1;
          em.r0      = ait_pkg::make_result(ait_pkg::EV_APP_DESC, cur_org, cur_app,
                                            8'd0, cur_acc[7:0], size, 32'd0);
          dleft_next = {1'b0, data_byte};
          if (data_byte == 8'd0) begin
            desc_end = 1'b1;
            dcnt_chk = adcnt_next;
            lcnt_chk = acnt_next;
          end else begin
            phase_next = ait_pkg::PH_DBODY;
          end
        end
        ait_pkg::PH_DBODY: begin
          dleft_next = cur_dleft - 9'd1;
          if (dleft_next == 9'd0) begin
            desc_end = 1'b1;
            dcnt_chk = cur_adcnt;
            lcnt_chk = cur_acnt;
          end
        end
        ait_pkg::PH_CRC: begin
          acc_next = {cur_acc[23:0], data_byte};
          fbc_next = cur_fbc + 3'd1;
          if (fbc_next >= 3'd4) begin
            fbc_next   = 3'd0;
            em.v0      = 1'b1;
            em.r0      = ait_pkg::make_result(ait_pkg::EV_CRC, 32'd0, 16'd0, 8'd0,
                                              8'd0, 9'd0, acc_next);
            em.v1      = 1'b1;
            em.r1      = ait_pkg::make_result(ait_pkg::EV_SECTION_END, 32'd0, 16'd0,
                                              8'd0, 8'd0, 9'd0, 32'd0);
            phase_next = ait_pkg::PH_DONE;
          end
        end
        default: begin
          // idle or finished: stray bytes are dropped
        end
      endcase

      if (desc_end) begin
        if (dcnt_chk >= {2'd0, adlen_next}) begin
          loop_chk = 1'b1;
        end else begin
          phase_next = ait_pkg::PH_DTAG;
        end
      end

      if (loop_chk) begin
        fbc_next = 3'd0;
        if (lcnt_chk >= {2'd0, alen_next}) begin
          if (crc_present) begin
            acc_next   = 32'd0;
            phase_next = ait_pkg::PH_CRC;
          end else begin
            phase_next = ait_pkg::PH_DONE;
            if (!em.v0) begin
              em.v0 = 1'b1;
              em.r0 = ait_pkg::make_result(ait_pkg::EV_SECTION_END, 32'd0, 16'd0,
                                           8'd0, 8'd0, 9'd0, 32'd0);
            end else begin
              em.v1 = 1'b1;
              em.r1 = ait_pkg::make_result(ait_pkg::EV_SECTION_END, 32'd0, 16'd0,
                                           8'd0, 8'd0, 9'd0, 32'd0);
            end
          end
        end else begin
          phase_next = ait_pkg::PH_AORG;
        end
      end
    end

    em.r0.last_of_run = !em.v1;
    em.r1.last_of_run = 1'b1;

    emit    = em;
    emit.v0 = take && em.v0;
    emit.v1 = take && em.v1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ait_pkg::PH_IDLE;
      fbc   <= 3'd0;
      acc   <= 32'd0;
      clen  <= 12'd0;
      ccnt  <= 14'd0;
      alen  <= 12'd0;
      acnt  <= 14'd0;
      adlen <= 12'd0;
      adcnt <= 14'd0;
      dleft <= 9'd0;
      org   <= 32'd0;
      app   <= 16'd0;
    end else if (take) begin
      phase <= phase_next;
      fbc   <= fbc_next;
      acc   <= acc_next;
      clen  <= clen_next;
      ccnt  <= ccnt_next;
      alen  <= alen_next;
      acnt  <= acnt_next;
      adlen <= adlen_next;
      adcnt <= adcnt_next;
      dleft <= dleft_next;
      org   <= org_next;
      app   <= app_next;
    end
  end

endmodule

// ----- rtl/ait_res_fifo.sv -----
module ait_res_fifo #(
  parameter int DEPTH = ait_pkg::ResDepth
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ait_pkg::ait_emit_t                 emit,
  input  logic                               pop,
  output ait_pkg::ait_result_t               head,
  output logic [$clog2(DEPTH + 1) - 1:0]     level
);

  localparam int PtrW   = $clog2(DEPTH);
  localparam int LevelW = $clog2(DEPTH + 1);

  ait_pkg::ait_result_t store [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW-1:0] wr_ptr1;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr);
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (emit.v0) begin
      store[wr_ptr] <= emit.r0;
    end
    if (emit.v1) begin
      store[wr_ptr1] <= emit.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (emit.v1) begin
        wr_ptr <= ptr_inc(wr_ptr1);
      end else if (emit.v0) begin
        wr_ptr <= wr_ptr1;
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      level <= level + LevelW'(emit.v0) + LevelW'(emit.v1) - LevelW'(pop);
    end
  end

endmodule

// ----- rtl/ait_section_parser_core.sv -----
// AIT section payload parser.
// in_ch carries one payload byte per transaction, starting right after the
// generic section header; first_byte marks the first byte and restarts the
// parse, table_ident is sampled with it (anything but 0x74 gives a single
// wrong-table event, then bytes are dropped until the next first byte).
// out_ch carries parse events: common descriptors, application headers,
// application descriptors, the CRC field and the section end. One byte
// yields zero, one or two events; last_of_run flags the final one.
// cfg_we/cfg_data write crc_present (reset 1); write it only while idle.
// Events: each is written to the result queue when its byte is taken and
// leaves from its head. Throughput: one byte per cycle while in_ch.ready is
// high. A byte is taken whenever the result queue has room for two
// events, so a stalled receiver back-pressures in_ch only once the queue
// (RES_DEPTH entries) nears full; with two-event bytes in a row the rate
// settles at the output rate of one event per cycle.
// Reset: synchronous; parser goes idle waiting for a first byte, queue
// empties, crc_present returns to 1.
module ait_section_parser_core #(
  parameter int RES_DEPTH = ait_pkg::ResDepth
) (
  input  logic            clk,
  input  logic            rst,
  ait_in_if.sink          in_ch,
  ait_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic            cfg_data
);

  localparam int LevelW = $clog2(RES_DEPTH + 1);

  logic                 crc_present;
  logic                 take;
  logic                 pop;
  logic [LevelW-1:0]    level;
  ait_pkg::ait_emit_t   emit;
  ait_pkg::ait_result_t head;

  // section syntax indicator
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_present <= 1'b1;
    end else if (cfg_we) begin
      crc_present <= cfg_data;
    end
  end

  // room for the worst case of two events keeps the byte stream moving
  assign in_ch.ready = (level <= LevelW'(RES_DEPTH - 2));
  assign take        = in_ch.valid && in_ch.ready;

  ait_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (in_ch.data_byte),
    .first_byte  (in_ch.first_byte),
    .table_ident (in_ch.table_ident),
    .crc_present (crc_present),
    .emit        (emit)
  );

  ait_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .emit  (emit),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  // output side
  assign out_ch.valid        = (level != '0);
  assign pop                 = out_ch.valid && out_ch.ready;
  assign out_ch.event_kind   = head.event_kind;
  assign out_ch.org_id       = head.org_id;
  assign out_ch.app_id       = head.app_id;
  assign out_ch.control_code = head.control_code;
  assign out_ch.desc_tag     = head.desc_tag;
  assign out_ch.desc_size    = head.desc_size;
  assign out_ch.tag_known    = head.tag_known;
  assign out_ch.crc_value    = head.crc_value;
  assign out_ch.last_of_run  = head.last_of_run;

  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LevelW'(RES_DEPTH))
    else $error("result queue overflow");

  // second event slot only after the first
  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    emit.v1 |-> emit.v0)
    else $error("second event without first");

  // events only come from a taken byte
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !take |-> (!emit.v0 && !emit.v1))
    else $error("event without input transaction");

  // a wrong table id gives exactly one wrong-table event
  a_wrong_table: assert property (@(posedge clk) disable iff (rst)
    (take && in_ch.first_byte && (in_ch.table_ident != ait_pkg::AIT_TABLE_ID))
      |-> (emit.v0 && !emit.v1 && (emit.r0.event_kind == ait_pkg::EV_WRONG_TABLE)))
    else $error("wrong table not reported");

endmodule

// ----- test/ait_section_parser_core_tb.sv -----
module ait_section_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transaction, config write or reset before the run
  // is declared hung. The slowest gap is the longest sender pause plus the
  // longest receiver stall plus the short settle before a config write.
  localparam int STUCK_LIMIT = 2000;
  localparam int BYTE_BUDGET = 1050;
  localparam int SETTLE      = 4;   // cycles after the last byte before cfg

  // Ways a random section is damaged on purpose
  localparam int SKEW_NONE = 0;
  localparam int SKEW_CLEN = 1;
  localparam int SKEW_ALEN = 2;
  localparam int SKEW_DLEN = 3;
  localparam int SKEW_CUT  = 4;

  typedef enum logic [1:0] {STEP_BYTE, STEP_CFG, STEP_DRAIN} step_kind_t;

  // One entry of the feed: a payload byte, a crc_present write, or a hold
  // until every outstanding event has come out.
  typedef struct packed {
    step_kind_t kind;
    logic [7:0] data;
    logic       first;
    logic [7:0] tid;
  } step_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_data;

  ait_in_if  in_ch ();
  ait_out_if out_ch ();

  ait_section_parser_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  step_t                events_pad_unused_q[$];
  step_t                feed_q[$];     // pending stimulus, filled up front
  ait_pkg::ait_result_t events_due[$]; // predicted events, oldest first

  int mismatches  = 0;
  int events_seen = 0;
  int bytes_taken = 0;
  int stuck_cycles = 0;
  int send_gap    = 0;
  int stall_left  = 0;
  int in_calm     = 0;
  int out_calm    = 0;
  int quiet_cnt   = 0;
  bit feed_idle   = 0;

  // --------------------------------------------------------------------
  // Parser shadow: mirrors the section walk byte by byte.
  // --------------------------------------------------------------------
  logic                crc_on;
  ait_pkg::ait_phase_t sec_phase;
  logic [2:0]          fld_cnt;
  logic [31:0]         fld_acc;     // also holds the pending tag / control code
  logic [11:0]         cmn_len;
  logic [13:0]         cmn_cnt;
  logic [11:0]         app_len;
  logic [13:0]         app_cnt;
  logic [11:0]         ad_len;
  logic [13:0]         ad_cnt;
  logic [8:0]          body_left;
  logic [31:0]         cur_org;
  logic [15:0]         cur_app;

  function automatic logic [13:0] add_sat(input logic [13:0] a, input logic [8:0] b);
    logic [14:0] s;
    s = {1'b0, a} + 15'(b);
    return s[14] ? 14'h3FFF : s[13:0];
  endfunction

  task automatic clear_section();
    fld_cnt   = '0;
    fld_acc   = '0;
    cmn_len   = '0;
    cmn_cnt   = '0;
    app_len   = '0;
    app_cnt   = '0;
    ad_len    = '0;
    ad_cnt    = '0;
    body_left = '0;
    cur_org   = '0;
    cur_app   = '0;
  endtask

  // Fields that mean nothing for a kind are zero.
  task automatic note_event(input ait_pkg::ait_event_t kind, input logic [7:0] tag,
                            input logic [8:0] size, input logic [7:0] ctrl,
                            input logic [31:0] crc);
    ait_pkg::ait_result_t r;
    logic                 app_kind;
    logic                 desc_kind;
    app_kind  = (kind == ait_pkg::EV_APP_HEADER) || (kind == ait_pkg::EV_APP_DESC);
    desc_kind = (kind == ait_pkg::EV_COMMON_DESC) || (kind == ait_pkg::EV_APP_DESC);
    r = '0;
    r.event_kind = kind;
    if (app_kind) begin
      r.org_id = cur_org;
      r.app_id = cur_app;
    end
    if (kind == ait_pkg::EV_APP_HEADER) r.control_code = ctrl;
    if (desc_kind) begin
      r.desc_tag  = tag;
      r.desc_size = size;
      r.tag_known = (tag <= 8'h04) || (tag == 8'h06) || (tag == 8'h07);
    end
    if (kind == ait_pkg::EV_CRC) r.crc_value = crc;
    events_due = {events_due, r};
  endtask

  task automatic common_next();
    fld_cnt   = '0;
    sec_phase = (cmn_cnt >= 14'(cmn_len)) ? ait_pkg::PH_ALEN : ait_pkg::PH_CTAG;
  endtask

  // Application loop done? Then either the CRC field or the section end.
  task automatic app_loop_next();
    fld_cnt = '0;
    if (app_cnt >= 14'(app_len)) begin
      if (crc_on) begin
        fld_acc   = '0;
        sec_phase = ait_pkg::PH_CRC;
      end else begin
        note_event(ait_pkg::EV_SECTION_END, 8'd0, 9'd0, 8'd0, 32'd0);
        sec_phase = ait_pkg::PH_DONE;
      end
    end else begin
      sec_phase = ait_pkg::PH_AORG;
    end
  endtask

  task automatic app_desc_next();
    if (ad_cnt >= 14'(ad_len)) app_loop_next();
    else sec_phase = ait_pkg::PH_DTAG;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic first,
                              input logic [7:0] tid);
    logic [8:0]           sz;
    int                   run_base;
    ait_pkg::ait_result_t tail;
    run_base = events_due.size();
    sz = {1'b0, b} + 9'd2;
    if (first) begin
      clear_section();
      if (tid == ait_pkg::AIT_TABLE_ID) begin
        sec_phase = ait_pkg::PH_CLEN;
      end else begin
        note_event(ait_pkg::EV_WRONG_TABLE, 8'd0, 9'd0, 8'd0, 32'd0);
        sec_phase = ait_pkg::PH_DONE;
      end
    end
    // a wrong-table first byte is consumed by the restart alone
    if (!first || tid == ait_pkg::AIT_TABLE_ID) begin
      case (sec_phase)
        ait_pkg::PH_CLEN: begin
          if (fld_cnt == 0) begin
            fld_acc = {28'd0, b[3:0]};
            fld_cnt = 3'd1;
          end else begin
            cmn_len = {fld_acc[3:0], b};
            cmn_cnt = '0;
            common_next();
          end
        end
        ait_pkg::PH_CTAG: begin
          fld_acc   = {24'd0, b};
          sec_phase = ait_pkg::PH_CDLEN;
        end
        ait_pkg::PH_CDLEN: begin
          cmn_cnt = add_sat(cmn_cnt, sz);
          note_event(ait_pkg::EV_COMMON_DESC, fld_acc[7:0], sz, 8'd0, 32'd0);
          body_left = {1'b0, b};
          if (b == 8'd0) common_next();
          else sec_phase = ait_pkg::PH_CBODY;
        end
        ait_pkg::PH_CBODY: begin
          body_left = body_left - 9'd1;
          if (body_left == 9'd0) common_next();
        end
        ait_pkg::PH_ALEN: begin
          if (fld_cnt == 0) begin
            fld_acc = {28'd0, b[3:0]};
            fld_cnt = 3'd1;
          end else begin
            app_len = {fld_acc[3:0], b};
            app_cnt = '0;
            app_loop_next();
          end
        end
        ait_pkg::PH_AORG: begin
          cur_org = {cur_org[23:0], b};
          fld_cnt = fld_cnt + 3'd1;
          if (fld_cnt >= 3'd4) begin
            fld_cnt   = '0;
            sec_phase = ait_pkg::PH_AREST;
          end
        end
        ait_pkg::PH_AREST: begin
          if (fld_cnt < 3'd2) begin
            cur_app = {cur_app[7:0], b};
            fld_cnt = fld_cnt + 3'd1;
          end else if (fld_cnt == 3'd2) begin
            fld_acc = {24'd0, b};
            fld_cnt = fld_cnt + 3'd1;
          end else if (fld_cnt == 3'd3) begin
            ad_len  = {b[3:0], 8'd0};
            fld_cnt = fld_cnt + 3'd1;
          end else begin
            ad_len[7:0] = b;
            ad_cnt  = '0;
            app_cnt = add_sat(app_cnt, 9'd9);
            note_event(ait_pkg::EV_APP_HEADER, 8'd0, 9'd0, fld_acc[7:0], 32'd0);
            fld_cnt = '0;
            app_desc_next();
          end
        end
        ait_pkg::PH_DTAG: begin
          fld_acc   = {24'd0, b};
          sec_phase = ait_pkg::PH_DDLEN;
        end
        ait_pkg::PH_DDLEN: begin
          ad_cnt  = add_sat(ad_cnt, sz);
          app_cnt = add_sat(app_cnt, sz);
          note_event(ait_pkg::EV_APP_DESC, fld_acc[7:0], sz, 8'd0, 32'd0);
          body_left = {1'b0, b};
          if (b == 8'd0) app_desc_next();
          else sec_phase = ait_pkg::PH_DBODY;
        end
        ait_pkg::PH_DBODY: begin
          body_left = body_left - 9'd1;
          if (body_left == 9'd0) app_desc_next();
        end
        ait_pkg::PH_CRC: begin
          fld_acc = {fld_acc[23:0], b};
          fld_cnt = fld_cnt + 3'd1;
          if (fld_cnt >= 3'd4) begin
            fld_cnt = '0;
            note_event(ait_pkg::EV_CRC, 8'd0, 9'd0, 8'd0, fld_acc);
            note_event(ait_pkg::EV_SECTION_END, 8'd0, 9'd0, 8'd0, 32'd0);
            sec_phase = ait_pkg::PH_DONE;
          end
        end
        default: ;  // idle or done: stray bytes are dropped
      endcase
    end
    // flag the final event of this byte
    if (events_due.size() > run_base) begin
      tail = events_due[events_due.size() - 1];
      tail.last_of_run = 1'b1;
      events_due[events_due.size() - 1] = tail;
    end
  endtask

  // --------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic first, input logic [7:0] tid);
    step_t s;
    s.kind  = STEP_BYTE;
    s.data  = b;
    s.first = first;
    s.tid   = tid;
    feed_q = {feed_q, s};
  endtask

  task automatic queue_ctl(input step_kind_t k, input logic v);
    step_t s;
    s.kind  = k;
    s.data  = {7'd0, v};
    s.first = 1'b0;
    s.tid   = 8'd0;
    feed_q = {feed_q, s};
  endtask

  // Mostly back to back, some short gaps, a few long ones, and now and
  // then a calm stretch with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // tag, length, body; small bodies mostly, rarely near the 255 maximum
  task automatic add_desc(ref logic [7:0] q[$]);
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 50) q = {q, 8'($urandom_range(0, 8))};
    else q = {q, 8'($urandom)};
    r = $urandom_range(0, 99);
    if (r < 85) len = $urandom_range(0, 6);
    else if (r < 97) len = $urandom_range(7, 30);
    else len = $urandom_range(200, 255);
    q = {q, 8'(len)};
    repeat (len) q = {q, 8'($urandom)};
  endtask

  function automatic logic [11:0] skew_len(input int len);
    int v;
    if ($urandom_range(0, 9) == 0) return 12'($urandom);
    v = len + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    return 12'(v);
  endfunction

  // One AIT payload: common loop, application loop, optional CRC. Most are
  // consistent; the rest get a wrong loop length or are cut short.
  task automatic add_section(input logic with_crc, output int nbytes);
    logic [7:0]  cmn[$];
    logic [7:0]  apps[$];
    logic [7:0]  descs[$];
    logic [7:0]  sec[$];
    logic [11:0] clen;
    logic [11:0] alen;
    logic [11:0] dlen;
    int          skew;
    int          n;
    skew = ($urandom_range(0, 99) < 80) ? SKEW_NONE : $urandom_range(SKEW_CLEN, SKEW_CUT);
    repeat ($urandom_range(0, 2)) add_desc(cmn);
    n = $urandom_range(0, 3);
    for (int a = 0; a < n; a++) begin
      descs.delete();
      repeat ($urandom_range(0, 3)) add_desc(descs);
      dlen = (skew == SKEW_DLEN && a == 0) ? skew_len(descs.size()) : 12'(descs.size());
      repeat (7) apps = {apps, 8'($urandom)};  // org id, app id, control code
      apps = {apps, {4'($urandom), dlen[11:8]}};
      apps = {apps, dlen[7:0]};
      foreach (descs[i]) apps = {apps, descs[i]};
    end
    clen = (skew == SKEW_CLEN) ? skew_len(cmn.size()) : 12'(cmn.size());
    alen = (skew == SKEW_ALEN) ? skew_len(apps.size()) : 12'(apps.size());
    sec = {sec, {4'($urandom), clen[11:8]}};
    sec = {sec, clen[7:0]};
    foreach (cmn[i]) sec = {sec, cmn[i]};
    sec = {sec, {4'($urandom), alen[11:8]}};
    sec = {sec, alen[7:0]};
    foreach (apps[i]) sec = {sec, apps[i]};
    if (with_crc) repeat (4) sec = {sec, 8'($urandom)};
    nbytes = (skew == SKEW_CUT) ? $urandom_range(1, sec.size()) : sec.size();
    queue_byte(sec[0], 1'b1, ait_pkg::AIT_TABLE_ID);
    for (int i = 1; i < nbytes; i++) queue_byte(sec[i], 1'b0, 8'($urandom));
  endtask

  function automatic string event_text(input ait_pkg::ait_result_t r);
    return $sformatf("kind=%0d org=%h app=%h ctrl=%h tag=%h size=%0d known=%b crc=%h last=%b",
                     r.event_kind, r.org_id, r.app_id, r.control_code, r.desc_tag,
                     r.desc_size, r.tag_known, r.crc_value, r.last_of_run);
  endfunction

  // --------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------
  // Byte driver. Predicts at the edge a transaction completes, holds the
  // byte while ready is low, and only touches crc_present once the parser
  // has gone quiet.
  // --------------------------------------------------------------------
  always @(posedge clk) begin : feed_bytes
    step_t      head;
    logic       took;
    logic       nv;
    logic       nwe;
    logic       ncfg;
    logic       nfirst;
    logic       quiet;
    logic [7:0] ndata;
    logic [7:0] ntid;
    if (rst) begin
      in_ch.valid <= 1'b0;
      cfg_we      <= 1'b0;
      quiet_cnt   = 0;
      send_gap    = 0;
      feed_idle   = 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        predict_byte(in_ch.data_byte, in_ch.first_byte, in_ch.table_ident);
        bytes_taken++;
      end
      if (in_ch.valid) quiet_cnt = 0;
      else if (quiet_cnt < SETTLE) quiet_cnt++;
      // a byte may cause nothing, so give the parser a few cycles too
      quiet = (events_due.size() == 0) && (quiet_cnt >= SETTLE);

      nv     = in_ch.valid && !took;
      ndata  = in_ch.data_byte;
      nfirst = in_ch.first_byte;
      ntid   = in_ch.table_ident;
      nwe    = 1'b0;
      ncfg   = cfg_data;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (feed_q.size() != 0) begin
          head = feed_q[0];
          case (head.kind)
            STEP_BYTE: begin
              nv     = 1'b1;
              ndata  = head.data;
              nfirst = head.first;
              ntid   = head.tid;
              void'(feed_q.pop_front());
              send_gap = pick_gap(in_calm);
            end
            STEP_CFG: begin
              if (quiet) begin
                nwe    = 1'b1;
                ncfg   = head.data[0];
                crc_on = head.data[0];
                void'(feed_q.pop_front());
              end
            end
            default: begin  // drain: wait for every event to come out
              if (quiet) void'(feed_q.pop_front());
            end
          endcase
        end
      end
      feed_idle = (feed_q.size() == 0) && !nv;
      in_ch.valid       <= nv;
      in_ch.data_byte   <= ndata;
      in_ch.first_byte  <= nfirst;
      in_ch.table_ident <= ntid;
      cfg_we   <= nwe;
      cfg_data <= ncfg;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin : pace_events
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left   = pick_gap(out_calm);
    end
  end

  // --------------------------------------------------------------------
  // Event checker: every output transaction against the oldest prediction
  // --------------------------------------------------------------------
  always @(posedge clk) begin : check_events
    ait_pkg::ait_result_t got;
    ait_pkg::ait_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      events_seen++;
      got = {out_ch.event_kind, out_ch.org_id, out_ch.app_id, out_ch.control_code,
             out_ch.desc_tag, out_ch.desc_size, out_ch.tag_known, out_ch.crc_value,
             out_ch.last_of_run};
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected event %s", $realtime, event_text(got));
      end else begin
        want = events_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: event mismatch", $realtime);
            $display("  expected %s", event_text(want));
            $display("  actual   %s", event_text(got));
          end
        end
      end
    end
  end

  // Hang detector
  always @(posedge clk) begin : watchdog
    if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no transaction for %0d cycles, %0d events still due",
                 stuck_cycles, events_due.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------
  initial begin : run_test
    int         useful;
    int         nb;
    int         sections;
    int         wrong_starts;
    int         cfg_writes;
    bit         drained;
    logic       crc_sel;
    logic [7:0] wt;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_data          = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'd0;
    in_ch.first_byte  = 1'b0;
    in_ch.table_ident = 8'd0;
    out_ch.ready      = 1'b0;

    clear_section();
    crc_on    = 1'b1;
    sec_phase = ait_pkg::PH_IDLE;

    useful       = 0;
    sections     = 0;
    wrong_starts = 1;
    cfg_writes   = 2;
    drained      = 1'b0;

    // wrong table id on a first byte
    queue_byte(8'h00, 1'b1, 8'hFF);
    // empty loops with a CRC (reset value of crc_present); high nibbles
    // of the length bytes must be masked off
    queue_byte(8'hF0, 1'b1, ait_pkg::AIT_TABLE_ID);
    queue_byte(8'h00, 1'b0, 8'h00);
    queue_byte(8'hF0, 1'b0, 8'h74);
    queue_byte(8'h00, 1'b0, 8'h00);
    repeat (4) queue_byte(8'hFF, 1'b0, 8'hFF);
    queue_ctl(STEP_CFG, 1'b0);
    // start a section, then restart it mid common loop
    queue_byte(8'h00, 1'b1, ait_pkg::AIT_TABLE_ID);
    queue_byte(8'h05, 1'b0, 8'h00);
    // two empty common descriptors (unknown 0x05, known 0x07), one
    // application with all-ones ids and an empty descriptor whose length
    // byte also closes the loop: descriptor and section end on one byte
    queue_byte(8'h00, 1'b1, ait_pkg::AIT_TABLE_ID);
    queue_byte(8'h04, 1'b0, 8'h00);
    queue_byte(8'h05, 1'b0, 8'h00);
    queue_byte(8'h00, 1'b0, 8'h00);
    queue_byte(8'h07, 1'b0, 8'h00);
    queue_byte(8'h00, 1'b0, 8'h00);
    queue_byte(8'h00, 1'b0, 8'h00);
    queue_byte(8'h0B, 1'b0, 8'h00);
    repeat (7) queue_byte(8'hFF, 1'b0, 8'h00);
    queue_byte(8'h00, 1'b0, 8'h00);
    queue_byte(8'h02, 1'b0, 8'h00);
    queue_byte(8'h00, 1'b0, 8'h00);
    queue_byte(8'h00, 1'b0, 8'h00);
    queue_ctl(STEP_CFG, 1'b1);
    crc_sel = 1'b1;
    useful  = 30;

    // random sections with noise in between
    while (useful < BYTE_BUDGET) begin
      if ($urandom_range(0, 99) < 6) begin
        wt = 8'($urandom);
        if (wt == ait_pkg::AIT_TABLE_ID) wt = ~wt;
        queue_byte(8'($urandom), 1'b1, wt);
        useful++;
        wrong_starts++;
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0, 8'($urandom));
      end else begin
        add_section(crc_sel, nb);
        useful += nb;
        sections++;
      end
      if ($urandom_range(0, 99) < 8)
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0, 8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        crc_sel = 1'($urandom_range(0, 1));
        queue_ctl(STEP_CFG, crc_sel);
        cfg_writes++;
      end
      if (!drained && useful > BYTE_BUDGET / 2) begin
        queue_ctl(STEP_DRAIN, 1'b0);
        drained = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!feed_idle) @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("fed %0d bytes: %0d random sections, %0d wrong-table starts, %0d crc_present writes",
             bytes_taken, sections, wrong_starts, cfg_writes);
    $display("checked %0d events, %0d mismatches", events_seen, mismatches);
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ait_pkg.sv
rtl/ait_if.sv
rtl/ait_parse.sv
rtl/ait_res_fifo.sv
rtl/ait_section_parser_core.sv
test/ait_section_parser_core_tb.sv
